### rtl/core/spvu_pkg.sv
// ----------------------------------------------------------------------------
// spvu_pkg
// Shared types and constants for the stereo peak vu meter core.
// ----------------------------------------------------------------------------
package spvu_pkg;

  // frame decimation inside a chunk, valid range 1..16
  localparam int DECIMATION = 4;
  localparam int PHASE_W    = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  localparam int SAMPLE_W = 16;
  localparam int PEAK_W   = 16;
  localparam int METER_W  = 7;
  localparam int PROD_W   = 22;   // 32768 * 100 fits in 22 bits
  localparam int SUM_W    = 9;    // 3 * 100 + 100 fits in 9 bits

  localparam logic [METER_W-1:0] PERCENT    = 7'd100;
  localparam logic [PEAK_W-1:0]  FULL_SCALE = 16'd32767;

  // frame mode codes
  localparam logic MODE_AUDIO = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       chunk_last;
  } frame_t;

  typedef struct packed {
    logic [METER_W-1:0] meter_left_out;
    logic [METER_W-1:0] meter_right_out;
  } meter_t;

  // per-cycle control shared by both channel lanes
  typedef struct packed {
    logic accept;     // frame transfer this cycle
    logic clear;      // transferred frame is a clear command
    logic last;       // transferred frame ends the chunk
    logic sample_on;  // frame sits on the decimation phase that is sampled
    logic s1_load;    // chunk end or clear enters stage 1
    logic s1_go;      // stage 1 moves to stage 2
    logic s2_go;      // stage 2 retires into the meters
    logic s2_clear;   // retiring item is a clear
  } lane_ctrl_t;

endpackage

### rtl/core/spvu_lane.sv
// ----------------------------------------------------------------------------
// spvu_lane
// One channel: magnitude and peak tracking, percent scaling, meter smoothing.
// ----------------------------------------------------------------------------
module spvu_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spvu_pkg::lane_ctrl_t                 ctrl,
  input  logic signed [spvu_pkg::SAMPLE_W-1:0] sample,
  output logic [spvu_pkg::METER_W-1:0]         meter_next
);

  logic [spvu_pkg::PEAK_W-1:0]  raw;
  logic [spvu_pkg::PEAK_W-1:0]  mag;
  logic [spvu_pkg::PEAK_W-1:0]  cand;
  logic [spvu_pkg::PEAK_W-1:0]  peak;
  logic [spvu_pkg::PEAK_W-1:0]  fin;
  logic [spvu_pkg::PROD_W-1:0]  prod;
  logic [spvu_pkg::METER_W-1:0] quo;
  logic [spvu_pkg::PEAK_W-1:0]  rem;
  logic [spvu_pkg::METER_W-1:0] quo_adj;
  logic [spvu_pkg::METER_W-1:0] pct_calc;
  logic [spvu_pkg::METER_W-1:0] pct;
  logic [spvu_pkg::METER_W-1:0] meter;
  logic [spvu_pkg::SUM_W-1:0]   sum;

  // stage 0: magnitude, -32768 maps to 32768
  always_comb begin
    raw  = sample;
    mag  = raw[spvu_pkg::PEAK_W-1] ? (~raw + 16'd1) : raw;
    cand = (ctrl.sample_on && (mag > peak)) ? mag : peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= '0;
    end else if (ctrl.accept) begin
      if (ctrl.clear || ctrl.last) begin
        peak <= '0;
      end else begin
        peak <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      fin <= cand;
    end
  end

  // stage 1: peak * 100 / 32767, quotient from a shift plus one correction
  always_comb begin
    prod     = {{(spvu_pkg::PROD_W-spvu_pkg::PEAK_W){1'b0}}, fin} * 22'(spvu_pkg::PERCENT);
    quo      = prod[spvu_pkg::PROD_W-1:15];
    rem      = {1'b0, prod[14:0]} + {{(spvu_pkg::PEAK_W-spvu_pkg::METER_W){1'b0}}, quo};
    quo_adj  = (rem >= spvu_pkg::FULL_SCALE) ? (quo + 7'd1) : quo;
    pct_calc = (quo_adj > spvu_pkg::PERCENT) ? spvu_pkg::PERCENT : quo_adj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_go) begin
      pct <= pct_calc;
    end
  end

  // stage 2: (old * 3 + new) / 4
  always_comb begin
    sum        = {1'b0, meter, 1'b0} + {2'b00, meter} + {2'b00, pct};
    meter_next = sum[spvu_pkg::SUM_W-1:2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meter <= '0;
    end else if (ctrl.s2_go) begin
      meter <= ctrl.s2_clear ? '0 : meter_next;
    end
  end

endmodule

### rtl/core/spvu_ctrl.sv
// ----------------------------------------------------------------------------
// spvu_ctrl
// Decimation phase, pipeline valid bits and both handshakes.
// ----------------------------------------------------------------------------
module spvu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  input  logic                 frame_mode,
  input  logic                 frame_last,
  input  logic                 meter_stall,
  output logic                 frame_stall,
  output logic                 meter_valid,
  output logic                 out_load,
  output spvu_pkg::lane_ctrl_t lane
);

  logic [spvu_pkg::PHASE_W-1:0] phase;
  logic                         s1_valid;
  logic                         s1_clear;
  logic                         s2_valid;
  logic                         s2_clear;
  logic                         accept;
  logic                         is_clear;
  logic                         s1_load;
  logic                         s1_go;
  logic                         s2_go;
  logic                         s2_ready;
  logic                         out_free;

  always_comb begin
    out_free    = !meter_valid || !meter_stall;
    s2_go       = s2_valid && (s2_clear || out_free);
    s2_ready    = !s2_valid || s2_go;
    s1_go       = s1_valid && s2_ready;
    frame_stall = s1_valid && !s2_ready;
    accept      = frame_valid && !frame_stall;
    is_clear    = (frame_mode == spvu_pkg::MODE_CLEAR);
    // only chunk ends and clears travel down the pipeline
    s1_load     = accept && (is_clear || frame_last);
    out_load    = s2_go && !s2_clear;

    lane.accept    = accept;
    lane.clear     = is_clear;
    lane.last      = frame_last;
    lane.sample_on = (phase == '0);
    lane.s1_load   = s1_load;
    lane.s1_go     = s1_go;
    lane.s2_go     = s2_go;
    lane.s2_clear  = s2_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (accept) begin
      if (is_clear || frame_last || (phase == spvu_pkg::PHASE_W'(spvu_pkg::DECIMATION - 1))) begin
        phase <= '0;
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s1_clear    <= 1'b0;
      s2_valid    <= 1'b0;
      s2_clear    <= 1'b0;
      meter_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
        s1_clear <= is_clear;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end

      if (s1_go) begin
        s2_valid <= 1'b1;
        s2_clear <= s1_clear;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end

      if (out_load) begin
        meter_valid <= 1'b1;
      end else if (!meter_stall) begin
        meter_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/stereo_peak_vu_meter_core.sv
// ----------------------------------------------------------------------------
// stereo_peak_vu_meter_core
// Path: a chunk-ending frame has its peak captured at its transfer, then percent
// scaling and smoothing into the output register, each done when the next stage
// or the output register is free. Throughput: one frame per cycle while
// frame_stall is low, set by the per-channel abs and compare lanes.
// Reset: synchronous; clears peaks, decimation phase, meters and all valid bits.
// ----------------------------------------------------------------------------
module stereo_peak_vu_meter_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  spvu_pkg::frame_t frame,
  output logic             meter_valid,
  input  logic             meter_stall,
  output spvu_pkg::meter_t meter
);

  spvu_pkg::lane_ctrl_t         lane;
  logic                         out_load;
  logic [spvu_pkg::METER_W-1:0] left_next;
  logic [spvu_pkg::METER_W-1:0] right_next;

  spvu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_mode  (frame.mode),
    .frame_last  (frame.chunk_last),
    .meter_stall (meter_stall),
    .frame_stall (frame_stall),
    .meter_valid (meter_valid),
    .out_load    (out_load),
    .lane        (lane)
  );

  spvu_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane),
    .sample     (frame.left_sample),
    .meter_next (left_next)
  );

  spvu_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (lane),
    .sample     (frame.right_sample),
    .meter_next (right_next)
  );

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      meter.meter_left_out  <= left_next;
      meter.meter_right_out <= right_next;
    end
  end

  a_meter_range: assert property (@(posedge clk) disable iff (rst)
    meter_valid |-> (meter.meter_left_out <= spvu_pkg::PERCENT) &&
                    (meter.meter_right_out <= spvu_pkg::PERCENT))
    else $error("meter above full scale");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (meter_valid && meter_stall))
    else $error("frame stalled while the output side is free");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!meter_valid || !meter_stall))
    else $error("output register overwritten before transfer");

endmodule

### tb/sv/tb_stereo_peak_vu_meter_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_peak_vu_meter_core
// Self-checking bench for the stereo peak vu meter core. A short table of
// directed frames (clear, extreme samples, unsampled chunk ends) is followed
// by random chunks under three idle/stall mixes. Every chunk end's meters come
// from a typed row or an in-bench model, checked field by field at the output.
// ----------------------------------------------------------------------------
module tb_stereo_peak_vu_meter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    spvu_pkg::frame_t f;
    bit               typed;
    spvu_pkg::meter_t want;
  } dir_row_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             frame_valid = 1'b0;
  logic             frame_stall;
  spvu_pkg::frame_t frame = '0;
  logic             meter_valid;
  logic             meter_stall = 1'b0;
  spvu_pkg::meter_t meter;

  spvu_pkg::meter_t meters_due[$];
  dir_row_t         dir_rows[$];
  int               err_count = 0;
  int               cycles = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  // in-bench copy of the chunk state
  int pk_left = 0, pk_right = 0, phase_q = 0;
  int lvl_left = 0, lvl_right = 0;

  stereo_peak_vu_meter_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame      (frame),
    .meter_valid(meter_valid),
    .meter_stall(meter_stall),
    .meter      (meter)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int sample_mag(input logic [15:0] raw);
    return raw[15] ? (32'h10000 - int'(raw)) : int'(raw);
  endfunction

  function automatic int to_pct(input int peak);
    int p;
    p = (peak * 100) / 32767;
    return (p > 100) ? 100 : p;
  endfunction

  // advances the chunk state by one frame, returns 1 when meters come out
  function automatic bit advance_meters(input spvu_pkg::frame_t f,
                                        output spvu_pkg::meter_t m);
    m = '0;
    if (f.mode == spvu_pkg::MODE_CLEAR) begin
      pk_left = 0; pk_right = 0; phase_q = 0;
      lvl_left = 0; lvl_right = 0;
      return 1'b0;
    end
    if (phase_q == 0) begin
      if (sample_mag(f.left_sample) > pk_left) pk_left = sample_mag(f.left_sample);
      if (sample_mag(f.right_sample) > pk_right) pk_right = sample_mag(f.right_sample);
    end
    phase_q = (phase_q + 1 >= spvu_pkg::DECIMATION) ? 0 : phase_q + 1;
    if (!f.chunk_last) return 1'b0;
    lvl_left = (lvl_left * 3 + to_pct(pk_left)) / 4;
    lvl_right = (lvl_right * 3 + to_pct(pk_right)) / 4;
    pk_left = 0; pk_right = 0; phase_q = 0;
    m.meter_left_out = spvu_pkg::METER_W'(lvl_left);
    m.meter_right_out = spvu_pkg::METER_W'(lvl_right);
    return 1'b1;
  endfunction

  // result side: random stall, check each transfer against the oldest expectation
  always @(posedge clk) begin
    spvu_pkg::meter_t exp_m;
    if (rst) begin
      meter_stall <= 1'b0;
    end else begin
      if (meter_valid && !meter_stall) begin
        if (meters_due.size() == 0) begin
          $display("%0t: unexpected meter transfer, actual %0d/%0d", $time,
                   meter.meter_left_out, meter.meter_right_out);
          err_count++;
        end else begin
          exp_m = meters_due.pop_front();
          if (meter.meter_left_out !== exp_m.meter_left_out) begin
            $display("%0t: meter_left_out expected %0d actual %0d", $time,
                     exp_m.meter_left_out, meter.meter_left_out);
            err_count++;
          end
          if (meter.meter_right_out !== exp_m.meter_right_out) begin
            $display("%0t: meter_right_out expected %0d actual %0d", $time,
                     exp_m.meter_right_out, meter.meter_right_out);
            err_count++;
          end
        end
      end
      meter_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_frame(input spvu_pkg::frame_t f, input bit typed,
                            input spvu_pkg::meter_t want);
    spvu_pkg::meter_t m;
    while ($urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    if (advance_meters(f, m)) meters_due.push_back(typed ? want : m);
  endtask

  // hold the sender off until every expected meter has come out
  task automatic wait_drained();
    frame_valid <= 1'b0;
    do @(posedge clk); while (meters_due.size() != 0);
  endtask

  task automatic add_row(input logic md, input int l, input int r, input logic last,
                         input bit typed, input int wl, input int wr);
    dir_row_t row;
    row.f.mode = md;
    row.f.left_sample = 16'(l);
    row.f.right_sample = 16'(r);
    row.f.chunk_last = last;
    row.typed = typed;
    row.want.meter_left_out = spvu_pkg::METER_W'(wl);
    row.want.meter_right_out = spvu_pkg::METER_W'(wr);
    dir_rows.push_back(row);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(2)) - 1);
      3, 4: return 16'(int'($urandom_range(2000)) - 1000);
      default: return 16'($urandom);
    endcase
  endfunction

  // random chunks, with now and then a clear cutting a chunk short
  task automatic run_chunks(input int n_items);
    spvu_pkg::frame_t f;
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
      for (int k = 0; k < len; k++) begin
        f.mode = ($urandom_range(39) == 0) ? spvu_pkg::MODE_CLEAR : spvu_pkg::MODE_AUDIO;
        f.left_sample = pick_sample();
        f.right_sample = pick_sample();
        f.chunk_last = (k == len - 1) ? 1'b1 : 1'($urandom);
        if (f.mode == spvu_pkg::MODE_AUDIO && k != len - 1) f.chunk_last = 1'b0;
        push_frame(f, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(49) == 0) wait_drained();
    end
  endtask

  initial begin
    // mode, left, right, last, typed, left meter, right meter
    add_row(spvu_pkg::MODE_CLEAR, 'h1234, -32768, 1, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 0, 0, 1, 1, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 32767, -32768, 1, 1, 25, 25);
    add_row(spvu_pkg::MODE_AUDIO, -32768, 32767, 1, 1, 43, 43);
    add_row(spvu_pkg::MODE_AUDIO, -1, 1, 0, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 32767, 32767, 0, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, -32768, -32768, 0, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 16384, -16384, 0, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 100, -200, 0, 0, 0, 0);
    // chunk end off the sampled phase still updates
    add_row(spvu_pkg::MODE_AUDIO, 32767, -32768, 1, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 32767, 32767, 1, 0, 0, 0);
    add_row(spvu_pkg::MODE_CLEAR, 32767, 32767, 1, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 1, -1, 1, 1, 0, 0);
    add_row(spvu_pkg::MODE_CLEAR, 'h5555, 'hAAAA, 0, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 'h5555, 'hAAAA, 0, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 0, 0, 1, 0, 0, 0);
    add_row(spvu_pkg::MODE_AUDIO, 'hAAAA, 'h5555, 1, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_stall_pct = 85;
    foreach (dir_rows[i]) push_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    run_chunks(400);
    wait_drained();

    send_idle_pct = 85;
    recv_stall_pct = 29;
    run_chunks(400);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_chunks(400);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/spvu_pkg.sv
rtl/core/spvu_lane.sv
rtl/core/spvu_ctrl.sv
rtl/core/stereo_peak_vu_meter_core.sv
tb/sv/tb_stereo_peak_vu_meter_core.sv
